### design/bss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bss_pkg
// Shared types and constants for the balance safety supervisor.
// ----------------------------------------------------------------------------
package bss_pkg;

   // Event selector carried in req_tuser
   typedef enum logic [2:0] {
      OP_UPDATE = 3'd0,
      OP_ARM    = 3'd1,
      OP_DISARM = 3'd2,
      OP_DRIVE  = 3'd3,
      OP_CLEAR  = 3'd4
   } opcode_type;

   // Supervisor mode, one-hot
   typedef enum logic [6:0] {
      MODE_BOOT     = 7'b000_0001,
      MODE_CALIB    = 7'b000_0010,
      MODE_DISARMED = 7'b000_0100,
      MODE_ARMED    = 7'b000_1000,
      MODE_DRIVING  = 7'b001_0000,
      MODE_FALLEN   = 7'b010_0000,
      MODE_FAULT    = 7'b100_0000
   } mode_type;

   // Reported mode codes
   localparam logic [2:0] CODE_BOOT     = 3'd0;
   localparam logic [2:0] CODE_CALIB    = 3'd1;
   localparam logic [2:0] CODE_DISARMED = 3'd2;
   localparam logic [2:0] CODE_ARMED    = 3'd3;
   localparam logic [2:0] CODE_DRIVING  = 3'd4;
   localparam logic [2:0] CODE_FALLEN   = 3'd5;
   localparam logic [2:0] CODE_FAULT    = 3'd6;

   // Register indexes on the csr port
   localparam logic CSR_FALL_ANGLE = 1'b0;
   localparam logic CSR_FALL_TIME  = 1'b1;

   localparam int unsigned ANGLE_W = 15;
   localparam int unsigned FTIME_W = 24;
   localparam int unsigned PITCH_W = 16;
   localparam int unsigned MAG_W   = PITCH_W + 1;
   localparam int unsigned FLAGS_W = 8;
   localparam int unsigned CODE_W  = 3;

   localparam logic [ANGLE_W-1:0] FALL_ANGLE_RST = 15'd5760;
   localparam logic [FTIME_W-1:0] FALL_TIME_RST  = 24'd500000;

   // Health flags, highest bit first; imu_ok lands in tdata bit 0
   typedef struct packed {
      logic zero_output_ack;
      logic upright;
      logic motor_link_ok;
      logic motor_feedback_ok;
      logic controller_failed;
      logic loop_ok;
      logic calibrated;
      logic imu_ok;
   } flags_type;

   // Registered event, minus the timestamp
   typedef struct packed {
      opcode_type         opcode;
      flags_type          flags;
      logic [PITCH_W-1:0] pitch;
      logic               drive_request;
   } event_type;

   // Settled result of one event
   typedef struct packed {
      logic [CODE_W-1:0] mode;
      logic              output_enabled;
      logic              accepted;
   } result_type;

   function automatic logic [CODE_W-1:0] mode_code(input mode_type m);
      logic [CODE_W-1:0] c;
      unique case (m)
         MODE_BOOT:     c = CODE_BOOT;
         MODE_CALIB:    c = CODE_CALIB;
         MODE_DISARMED: c = CODE_DISARMED;
         MODE_ARMED:    c = CODE_ARMED;
         MODE_DRIVING:  c = CODE_DRIVING;
         MODE_FALLEN:   c = CODE_FALLEN;
         MODE_FAULT:    c = CODE_FAULT;
         default:       c = CODE_BOOT;
      endcase
      return c;
   endfunction

endpackage

### design/bss_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bss_in_stage
// Input register: captures one event beat and unpacks the tdata fields.
// ----------------------------------------------------------------------------
module bss_in_stage #(
   parameter int unsigned TIME_BITS = 48,
   parameter int unsigned DATA_W    = 80
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [DATA_W-1:0]      req_tdata,
   input  logic [2:0]             req_tuser,
   input  logic                   advance,     // held event is consumed
   output logic                   evt_valid,
   output bss_pkg::event_type     evt,
   output logic [TIME_BITS-1:0]   evt_now
);
   import bss_pkg::*;

   localparam int unsigned PITCH_LO = FLAGS_W;
   localparam int unsigned TIME_LO  = FLAGS_W + PITCH_W;
   localparam int unsigned DRIVE_LO = TIME_LO + TIME_BITS;

   logic                 valid_ff, valid_in;
   event_type            evt_ff, evt_in;
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic                 take;

   assign req_tready = !valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      valid_in             = take ? 1'b1 : (advance ? 1'b0 : valid_ff);
      evt_in.opcode        = opcode_type'(req_tuser);
      evt_in.flags         = flags_type'(req_tdata[FLAGS_W-1:0]);
      evt_in.pitch         = req_tdata[PITCH_LO +: PITCH_W];
      evt_in.drive_request = req_tdata[DRIVE_LO];
      now_in               = req_tdata[TIME_LO +: TIME_BITS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         evt_ff <= evt_in;
         now_ff <= now_in;
      end
   end

   assign evt_valid = valid_ff;
   assign evt       = evt_ff;
   assign evt_now   = now_ff;

endmodule

### design/bss_next_state.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bss_next_state
// Mode transition, fall timer and accept flag for one event.
// ----------------------------------------------------------------------------
module bss_next_state #(
   parameter int unsigned TIME_BITS = 48
) (
   input  bss_pkg::event_type              evt,
   input  logic [TIME_BITS-1:0]            evt_now,
   input  bss_pkg::mode_type               cur_mode,
   input  logic [TIME_BITS-1:0]            cur_start,
   input  logic [bss_pkg::ANGLE_W-1:0]     fall_angle,
   input  logic [bss_pkg::FTIME_W-1:0]     fall_time,
   output bss_pkg::mode_type               nxt_mode,
   output logic [TIME_BITS-1:0]            nxt_start,
   output logic                            accepted
);
   import bss_pkg::*;

   flags_type            f;
   logic                 diag_ok;
   logic                 live;
   logic [MAG_W-1:0]     pitch_x;
   logic [MAG_W-1:0]     mag;
   logic                 level;
   logic [TIME_BITS-1:0] age;
   logic                 expired;
   logic                 health_bad;

   always_comb begin
      f          = evt.flags;
      diag_ok    = f.imu_ok && f.calibrated && f.loop_ok && !f.controller_failed;
      live       = (cur_mode == MODE_ARMED) || (cur_mode == MODE_DRIVING);
      // 17-bit magnitude so the most negative pitch stays positive
      pitch_x    = {evt.pitch[PITCH_W-1], evt.pitch};
      mag        = evt.pitch[PITCH_W-1] ? (~pitch_x + MAG_W'(1)) : pitch_x;
      level      = mag <= MAG_W'(fall_angle);
      age        = evt_now - cur_start;
      expired    = age >= TIME_BITS'(fall_time);
      health_bad = !f.imu_ok || !f.loop_ok || f.controller_failed ||
                   (live && (!f.motor_feedback_ok || !f.motor_link_ok));

      nxt_mode  = cur_mode;
      nxt_start = cur_start;
      accepted  = 1'b0;

      unique case (evt.opcode)
         OP_UPDATE: begin
            priority if (cur_mode == MODE_BOOT) begin
               nxt_mode = MODE_CALIB;
            end else if (cur_mode == MODE_CALIB) begin
               if (!f.imu_ok) begin
                  nxt_mode = MODE_FAULT;
               end else if (f.calibrated) begin
                  nxt_mode = MODE_DISARMED;
               end
            end else if (health_bad) begin
               nxt_mode  = MODE_FAULT;
               nxt_start = '0;
            end else if (!live) begin
               nxt_mode = cur_mode;
            end else if (level) begin
               nxt_start = '0;
            end else if (cur_start == '0) begin
               // timer idle: start it (a start at time zero stays idle)
               nxt_start = evt_now;
            end else if (expired) begin
               nxt_mode  = MODE_FALLEN;
               nxt_start = '0;
            end
         end
         OP_ARM: begin
            if (diag_ok && f.motor_feedback_ok && f.motor_link_ok && f.upright &&
                f.zero_output_ack &&
                (cur_mode == MODE_DISARMED || cur_mode == MODE_FALLEN)) begin
               nxt_mode  = MODE_ARMED;
               nxt_start = '0;
               accepted  = 1'b1;
            end
         end
         OP_DISARM: begin
            if (cur_mode != MODE_FAULT) begin
               nxt_mode = MODE_DISARMED;
            end
            nxt_start = '0;
         end
         OP_DRIVE: begin
            if (evt.drive_request && cur_mode == MODE_ARMED) begin
               nxt_mode = MODE_DRIVING;
            end else if (!evt.drive_request && cur_mode == MODE_DRIVING) begin
               nxt_mode = MODE_ARMED;
            end
         end
         OP_CLEAR: begin
            if (cur_mode == MODE_FAULT && diag_ok) begin
               nxt_mode = MODE_DISARMED;
               accepted = 1'b1;
            end
         end
         default: begin
            nxt_mode = cur_mode;
         end
      endcase
   end

endmodule

### design/balance_safety_supervisor.sv
`timescale 1ns / 1ps
// A req beat passes the input register, then the result register, to rsp.
// Throughput: one event per cycle while rsp_tready allows; the mode and
//   fall timer registers are updated in the same cycle the result is
//   registered, so the next event sees them at once.
// Reset (synchronous, active high): mode boot, fall timer idle, fall_angle
//   5760, fall_time 500000, both pipeline stages empty.
// ----------------------------------------------------------------------------
// balance_safety_supervisor
// Safety supervisor for a self-balancing robot: mode machine with fall timer.
// ----------------------------------------------------------------------------
module balance_safety_supervisor #(
   parameter int unsigned TIME_BITS = 48
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // Event input
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // tdata, low bit up: imu_ok, calibrated, loop_ok, controller_failed,
   // motor_feedback_ok, motor_link_ok, upright, zero_output_ack,
   // pitch[15:0], now_time[TIME_BITS-1:0], drive_request, zero fill
   input  logic [((TIME_BITS+25+7)/8)*8-1:0]      req_tdata,
   // tuser: opcode[2:0]
   input  logic [2:0]                             req_tuser,
   // Result output
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // tdata, low bit up: mode[2:0], output_enabled, accepted, zero fill
   output logic [7:0]                             rsp_tdata,
   // Configuration writes
   input  logic                                   csr_we,
   input  logic                                   csr_index,
   input  logic [bss_pkg::FTIME_W-1:0]            csr_wdata
);
   import bss_pkg::*;

   localparam int unsigned DATA_W = ((TIME_BITS + 25 + 7) / 8) * 8;

   // Config registers
   logic [ANGLE_W-1:0]   fall_angle_ff;
   logic [FTIME_W-1:0]   fall_time_ff;

   // Supervisor state
   mode_type             mode_ff, mode_in;
   logic [TIME_BITS-1:0] start_ff, start_in;   // zero = timer idle

   // Result register
   logic                 rsp_valid_ff, rsp_valid_in;
   result_type           rsp_ff, rsp_in;

   // Stage 1 signals
   logic                 evt_valid;
   event_type            evt;
   logic [TIME_BITS-1:0] evt_now;
   logic                 advance;
   logic                 accepted;

   // Stage 1 moves on when the result slot is free or being drained.
   assign advance = evt_valid && (!rsp_valid_ff || rsp_tready);

   bss_in_stage #(
      .TIME_BITS (TIME_BITS),
      .DATA_W    (DATA_W)
   ) u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .advance    (advance),
      .evt_valid  (evt_valid),
      .evt        (evt),
      .evt_now    (evt_now)
   );

   bss_next_state #(
      .TIME_BITS (TIME_BITS)
   ) u_next_state (
      .evt        (evt),
      .evt_now    (evt_now),
      .cur_mode   (mode_ff),
      .cur_start  (start_ff),
      .fall_angle (fall_angle_ff),
      .fall_time  (fall_time_ff),
      .nxt_mode   (mode_in),
      .nxt_start  (start_in),
      .accepted   (accepted)
   );

   always_comb begin
      rsp_in.mode           = mode_code(mode_in);
      rsp_in.output_enabled = (mode_in == MODE_ARMED) || (mode_in == MODE_DRIVING);
      rsp_in.accepted       = accepted;
      rsp_valid_in          = advance ? 1'b1 :
                              ((rsp_valid_ff && rsp_tready) ? 1'b0 : rsp_valid_ff);
   end

   // Control state and config
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_BOOT;
         start_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         fall_angle_ff <= FALL_ANGLE_RST;
         fall_time_ff  <= FALL_TIME_RST;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            mode_ff  <= mode_in;
            start_ff <= start_in;
         end
         if (csr_we) begin
            unique case (csr_index)
               CSR_FALL_ANGLE: fall_angle_ff <= csr_wdata[ANGLE_W-1:0];
               CSR_FALL_TIME:  fall_time_ff  <= csr_wdata;
               default:        fall_time_ff  <= fall_time_ff;
            endcase
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_ff.accepted, rsp_ff.output_enabled, rsp_ff.mode};

endmodule
